// ===== sv/psb_pkg.sv =====
// Shared types, widths and codes for the priority semaphore bank.
package psb_pkg;

    localparam int NUM_SEMAPHORES_DEF = 8;
    localparam int MAX_TASKS_DEF      = 32;
    localparam int COUNT_WIDTH_DEF    = 16;

    localparam int MODE_W       = 2;
    localparam int SEM_ID_W     = 3;
    localparam int PRIO_W       = 6;
    localparam int TMO_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int SLOT_COUNT   = 8;   // semaphores a 3-bit id can address
    localparam int INIT_COUNT_W = 8;
    localparam int MASK_CFG_W   = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT   = 2'd0,
        MODE_SIGNAL = 2'd1,
        MODE_RESUME = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_REFUSED = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTING_MASK  = 1'd0,
        CFG_INITIAL_COUNTS = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SEM_ID_W-1:0] sem_id;
        logic [PRIO_W-1:0]   prio;
        logic                tmo_nz;
    } op_req_t;

    typedef struct packed {
        status_t             status;
        logic                rel_valid;
        logic [PRIO_W-1:0]   rel_prio;
    } op_rsp_t;

    typedef struct packed {
        logic                  wr_mask;
        logic                  wr_counts;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ===== sv/priority_semaphore_bank_top.sv =====
// Top level of the priority semaphore bank: stream ports, word registers, config port.
//
// On its way from s_ to m_, each word is captured in an input register,
// then the addressed semaphore's count and blocked mask are read, updated through
// a priority encoder over the mask, and written back in the same edge that loads
// the result register. One word is accepted per cycle while the result side
// drains; state written by one word is seen by the next. Configuration writes
// through cfg_* are never stalled (cfg_ready is always high) and must be made
// only while no word is in flight; index 0 sets the counting mask, index 1 loads
// the initial counts and clears every blocked mask.
module priority_semaphore_bank_top #(
    parameter int NUM_SEMAPHORES = psb_pkg::NUM_SEMAPHORES_DEF,
    parameter int MAX_TASKS      = psb_pkg::MAX_TASKS_DEF,
    parameter int COUNT_WIDTH    = psb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[1:0], sem_id[4:2], task_priority[10:5], timeout_ticks[42:11], zero fill
    input  logic [psb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], released_valid[2], released_priority[8:3], zero fill
    output logic [psb_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              in_vld_reg;
    logic              in_vld_next;
    psb_pkg::op_req_t  in_req_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    psb_pkg::op_rsp_t  out_rsp_reg;
    psb_pkg::op_rsp_t  rsp;
    psb_pkg::op_req_t  s_req;
    psb_pkg::cfg_wr_t  cfg;
    logic              advance;
    logic              op_fire;
    logic              s_fire;

    assign s_req.mode   = s_tdata[1:0];
    assign s_req.sem_id = s_tdata[4:2];
    assign s_req.prio   = s_tdata[10:5];
    assign s_req.tmo_nz = |s_tdata[42:11];

    assign cfg_ready     = 1'b1;
    assign cfg.wr_mask   = cfg_valid &&
                           (psb_pkg::cfg_idx_t'(cfg_index) == psb_pkg::CFG_COUNTING_MASK);
    assign cfg.wr_counts = cfg_valid &&
                           (psb_pkg::cfg_idx_t'(cfg_index) == psb_pkg::CFG_INITIAL_COUNTS);
    assign cfg.data      = cfg_data;

    // Result register moves when empty or taken; input register refills behind it.
    assign advance  = !out_vld_reg || m_tready;
    assign op_fire  = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_vld_next  = s_fire || (in_vld_reg && !advance);
    assign out_vld_next = op_fire || (out_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg <= s_req;
        end
        if (op_fire) begin
            out_rsp_reg <= rsp;
        end
    end

    psb_core #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .MAX_TASKS      (MAX_TASKS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .op_fire (op_fire),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_rsp_reg.rel_prio, out_rsp_reg.rel_valid,
                       out_rsp_reg.status};

    a_release_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == psb_pkg::ST_OK)
        else $error("release reported with non-ok status");

    a_no_release_no_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[8:3] == '0)
        else $error("released priority set without a release");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled with room in the word registers");

    a_held_word_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_req_reg))
        else $error("pending word lost or changed while stalled");

endmodule

// ===== sv/psb_prienc.sv =====
// Highest-set-bit encoder over the blocked-task mask.
module psb_prienc #(
    parameter int WIDTH = psb_pkg::MAX_TASKS_DEF
) (
    input  logic [WIDTH-1:0]          vec,
    output logic                      any,
    output logic [psb_pkg::PRIO_W-1:0] idx
);

    always_comb begin
        idx = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (vec[i]) begin
                idx = psb_pkg::PRIO_W'(i);
            end
        end
        any = |vec;
    end

endmodule

// ===== sv/psb_core.sv =====
// Semaphore state registers and the per-word wait/signal/resume update.
module psb_core #(
    parameter int NUM_SEMAPHORES = psb_pkg::NUM_SEMAPHORES_DEF,
    parameter int MAX_TASKS      = psb_pkg::MAX_TASKS_DEF,
    parameter int COUNT_WIDTH    = psb_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  psb_pkg::cfg_wr_t  cfg,
    input  logic              op_fire,
    input  psb_pkg::op_req_t  req,
    output psb_pkg::op_rsp_t  rsp
);

    localparam int NumSlots = (NUM_SEMAPHORES < psb_pkg::SLOT_COUNT) ?
                              NUM_SEMAPHORES : psb_pkg::SLOT_COUNT;
    localparam logic [32:0] CountMaxWide = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [COUNT_WIDTH-1:0] CountMax = CountMaxWide[COUNT_WIDTH-1:0];

    logic [psb_pkg::MASK_CFG_W-1:0] cmask_reg;
    logic [COUNT_WIDTH-1:0]         cnt_arr  [psb_pkg::SLOT_COUNT];
    logic [MAX_TASKS-1:0]           mask_arr [psb_pkg::SLOT_COUNT];

    logic [COUNT_WIDTH-1:0]     cnt_cur;
    logic [MAX_TASKS-1:0]       mask_cur;
    logic [COUNT_WIDTH-1:0]     cnt_new;
    logic [MAX_TASKS-1:0]       mask_new;
    logic [MAX_TASKS-1:0]       prio_bit;
    logic [MAX_TASKS-1:0]       mask_drop_top;
    logic [psb_pkg::PRIO_W-1:0] prio_m1;
    logic [psb_pkg::PRIO_W-1:0] top_idx;
    logic                       top_any;
    logic                       prio_ok;
    logic                       sem_ok;
    logic                       counting;

    function automatic logic [COUNT_WIDTH-1:0] reload_count(
        input logic [psb_pkg::INIT_COUNT_W-1:0] b,
        input logic                             is_cnt
    );
        logic [32:0] c;
        c = 33'(b);
        if (!is_cnt && c > 33'd1) begin
            c = 33'd1;
        end
        if (c > CountMaxWide) begin
            c = CountMaxWide;
        end
        return c[COUNT_WIDTH-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmask_reg <= '0;
        end else if (cfg.wr_mask) begin
            cmask_reg <= cfg.data[psb_pkg::MASK_CFG_W-1:0];
        end
    end

    // One count and one mask per addressable semaphore that the bank holds.
    for (genvar s = 0; s < psb_pkg::SLOT_COUNT; s++) begin : g_slot
        if (s < NumSlots) begin : g_live
            logic [COUNT_WIDTH-1:0] cnt_reg;
            logic [MAX_TASKS-1:0]   mask_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cnt_reg  <= '0;
                    mask_reg <= '0;
                end else if (cfg.wr_counts) begin
                    cnt_reg  <= reload_count(
                        cfg.data[psb_pkg::INIT_COUNT_W*s +: psb_pkg::INIT_COUNT_W],
                        cmask_reg[s]);
                    mask_reg <= '0;
                end else if (op_fire && sem_ok &&
                             req.sem_id == psb_pkg::SEM_ID_W'(s)) begin
                    cnt_reg  <= cnt_new;
                    mask_reg <= mask_new;
                end
            end

            assign cnt_arr[s]  = cnt_reg;
            assign mask_arr[s] = mask_reg;
        end else begin : g_none
            assign cnt_arr[s]  = '0;
            assign mask_arr[s] = '0;
        end
    end

    assign sem_ok   = 32'(req.sem_id) < NUM_SEMAPHORES;
    assign cnt_cur  = cnt_arr[req.sem_id];
    assign mask_cur = mask_arr[req.sem_id];
    assign counting = cmask_reg[req.sem_id];

    assign prio_ok = (req.prio != '0) && (32'(req.prio) <= MAX_TASKS);
    assign prio_m1 = req.prio - psb_pkg::PRIO_W'(1);

    psb_prienc #(
        .WIDTH (MAX_TASKS)
    ) u_prienc (
        .vec (mask_cur),
        .any (top_any),
        .idx (top_idx)
    );

    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            prio_bit[i]      = prio_ok && (prio_m1 == psb_pkg::PRIO_W'(i));
            mask_drop_top[i] = mask_cur[i] && (top_idx != psb_pkg::PRIO_W'(i));
        end
    end

    always_comb begin
        cnt_new       = cnt_cur;
        mask_new      = mask_cur;
        rsp.status    = psb_pkg::ST_REFUSED;
        rsp.rel_valid = 1'b0;
        rsp.rel_prio  = '0;
        if (sem_ok) begin
            case (psb_pkg::mode_t'(req.mode))
                psb_pkg::MODE_WAIT: begin
                    if (cnt_cur != '0) begin
                        cnt_new    = cnt_cur - COUNT_WIDTH'(1);
                        rsp.status = psb_pkg::ST_OK;
                    end else if (req.tmo_nz && prio_ok) begin
                        mask_new   = mask_cur | prio_bit;
                        rsp.status = psb_pkg::ST_BLOCKED;
                    end
                end
                psb_pkg::MODE_SIGNAL: begin
                    if (top_any) begin
                        // Hand the unit straight to the highest blocked priority.
                        mask_new      = mask_drop_top;
                        rsp.status    = psb_pkg::ST_OK;
                        rsp.rel_valid = 1'b1;
                        rsp.rel_prio  = top_idx + psb_pkg::PRIO_W'(1);
                    end else if (counting ? (cnt_cur != CountMax) : (cnt_cur == '0)) begin
                        cnt_new    = cnt_cur + COUNT_WIDTH'(1);
                        rsp.status = psb_pkg::ST_OK;
                    end
                end
                psb_pkg::MODE_RESUME: begin
                    if (prio_ok) begin
                        rsp.status = ((mask_cur & prio_bit) == '0) ?
                                     psb_pkg::ST_OK : psb_pkg::ST_TIMEOUT;
                        mask_new   = mask_cur & ~prio_bit;
                    end
                end
                default: begin
                    rsp.status = psb_pkg::ST_REFUSED;
                end
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the priority semaphore bank: directed, pressure and random runs.
`timescale 1ns / 100ps

module testbench;
    import psb_pkg::*;

    localparam int               STALL_LIMIT = 2000;
    localparam int               HOLD_CYCLES = 400;
    localparam int               MAX_ERRORS_SHOWN = 10;
    localparam int               PHASE_ITEMS = 210;
    localparam logic [1:0]       MODE_UNUSED = 2'd3;
    localparam logic [15:0]      COUNT_MAX   = 16'hFFFF;

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [S_TDATA_W-1:0]        s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]        m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_COUNTING_MASK;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;

    // Shadow copy of the bank state and its registers
    logic [15:0]                 shadow_count [SLOT_COUNT];
    logic [31:0]                 shadow_blocked [SLOT_COUNT];
    logic [7:0]                  shadow_counting;
    logic [63:0]                 shadow_initial;

    op_rsp_t                     pending_replies [$];
    int                          errors = 0;
    int                          replies_seen = 0;
    int                          quiet_cycles = 0;
    int                          burst_left = 0;
    int                          hold_requested = 0;
    int                          hold_served = 0;
    int                          hold_left = 0;
    int                          phase_left = 0;
    int                          stall_pct = 0;

    priority_semaphore_bank_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void reload_counts();
        logic [15:0] c;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            c = 16'(shadow_initial[8*s +: 8]);
            // binary semaphores clamp to one
            if (!shadow_counting[s] && c > 16'd1) begin
                c = 16'd1;
            end
            shadow_count[s]   = c;
            shadow_blocked[s] = '0;
        end
    endfunction

    function automatic op_rsp_t apply_semaphore_op(logic [1:0] mode, logic [2:0] sem,
                                                    logic [5:0] prio, logic [31:0] tmo);
        op_rsp_t     r;
        logic        prio_ok;
        logic [31:0] prio_bit;
        logic [31:0] waiting;
        int          top;
        r.status    = ST_REFUSED;
        r.rel_valid = 1'b0;
        r.rel_prio  = '0;
        prio_ok  = (prio >= 6'd1) && (prio <= 6'(MAX_TASKS_DEF));
        prio_bit = prio_ok ? (32'd1 << (prio - 6'd1)) : 32'd0;
        case (mode)
            MODE_WAIT: begin
                if (shadow_count[sem] != 16'd0) begin
                    shadow_count[sem] = shadow_count[sem] - 16'd1;
                    r.status = ST_OK;
                end else if (tmo != 32'd0 && prio_ok) begin
                    shadow_blocked[sem] = shadow_blocked[sem] | prio_bit;
                    r.status = ST_BLOCKED;
                end
            end
            MODE_SIGNAL: begin
                waiting = shadow_blocked[sem];
                if (waiting != 32'd0) begin
                    // wake the highest blocked priority
                    top = 31;
                    while (!waiting[top]) top--;
                    shadow_blocked[sem][top] = 1'b0;
                    r.status    = ST_OK;
                    r.rel_valid = 1'b1;
                    r.rel_prio  = 6'(top + 1);
                end else if (shadow_counting[sem] ? (shadow_count[sem] != COUNT_MAX)
                                                  : (shadow_count[sem] == 16'd0)) begin
                    shadow_count[sem] = shadow_count[sem] + 16'd1;
                    r.status = ST_OK;
                end
            end
            MODE_RESUME: begin
                if (prio_ok) begin
                    r.status = ((shadow_blocked[sem] & prio_bit) == 32'd0) ? ST_OK : ST_TIMEOUT;
                    shadow_blocked[sem] = shadow_blocked[sem] & ~prio_bit;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_error(string msg);
        if (errors < MAX_ERRORS_SHOWN) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Track config writes and accepted words, check each result word
    always @(posedge aclk) begin : scoreboard
        op_rsp_t want;
        if (!aresetn) begin
            shadow_counting = '0;
            shadow_initial  = '0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                shadow_count[s]   = '0;
                shadow_blocked[s] = '0;
            end
            pending_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COUNTING_MASK: shadow_counting = cfg_data[7:0];
                    CFG_INITIAL_COUNTS: begin
                        shadow_initial = cfg_data;
                        reload_counts();
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                pending_replies.push_back(apply_semaphore_op(s_tdata[1:0], s_tdata[4:2],
                                                             s_tdata[10:5], s_tdata[42:11]));
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    note_error($sformatf("result word %0d arrived with none expected: %h",
                                         replies_seen, m_tdata));
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tdata[1:0] !== want.status || m_tdata[2] !== want.rel_valid ||
                        m_tdata[8:3] !== want.rel_prio) begin
                        note_error($sformatf(
                            "word %0d: expected status %0d rel %0d prio %0d, got %0d %0d %0d",
                            replies_seen, want.status, want.rel_valid, want.rel_prio,
                            m_tdata[1:0], m_tdata[2], m_tdata[8:3]));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random stall phases, plus long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requested) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            phase_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one word; returns right after the edge that accepts it, with valid still high
    task automatic send_word(logic [1:0] mode, logic [2:0] sem, logic [5:0] prio,
                             logic [31:0] tmo);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, tmo, prio, sem, mode};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic send_random_op(logic [2:0] sem_focus, int prio_base);
        logic [1:0]  mode;
        logic [2:0]  sem;
        logic [5:0]  prio;
        logic [31:0] tmo;
        int          pick;
        sem  = ($urandom_range(0, 9) < 7) ? sem_focus : 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        mode = (pick < 42) ? MODE_WAIT : (pick < 75) ? MODE_SIGNAL :
               (pick < 95) ? MODE_RESUME : MODE_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            prio = 6'(prio_base + $urandom_range(0, 3));
        end else if (pick < 9) begin
            prio = 6'($urandom_range(1, 32));
        end else begin
            prio = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        end
        pick = $urandom_range(0, 9);
        tmo  = (pick < 2) ? 32'd0 : (pick == 2) ? 32'hFFFF_FFFF : 32'($urandom);
        send_word(mode, sem, prio, tmo);
    endtask

    // Drop valid and let every expected word come back before touching registers
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset state: all binary with count zero
    task automatic test_after_reset();
        send_word(MODE_WAIT,   3'd0, 6'd1, 32'd0);
        send_word(MODE_WAIT,   3'd0, 6'd1, 32'hFFFF_FFFF);
        send_word(MODE_SIGNAL, 3'd0, 6'd9, 32'd0);
        send_word(MODE_RESUME, 3'd0, 6'd1, 32'd0);
        send_word(MODE_SIGNAL, 3'd0, 6'd9, 32'd0);
        send_word(MODE_SIGNAL, 3'd0, 6'd9, 32'd0);
        wait_idle();
    endtask

    // Wake order, priority range, resume outcomes and the unused mode
    task automatic test_priorities();
        write_reg(CFG_COUNTING_MASK, 64'hF0);
        write_reg(CFG_INITIAL_COUNTS, 64'hFF02_0000_0000_0201);
        send_word(MODE_WAIT,   3'd2, 6'd0,  32'd5);
        send_word(MODE_WAIT,   3'd2, 6'd33, 32'd5);
        send_word(MODE_WAIT,   3'd1, 6'd63, 32'd0);
        send_word(MODE_WAIT,   3'd2, 6'd32, 32'd1);
        send_word(MODE_WAIT,   3'd2, 6'd32, 32'd7);
        send_word(MODE_WAIT,   3'd2, 6'd1,  32'd2);
        send_word(MODE_SIGNAL, 3'd2, 6'd0,  32'd0);
        send_word(MODE_RESUME, 3'd2, 6'd63, 32'd0);
        send_word(MODE_RESUME, 3'd2, 6'd32, 32'd0);
        send_word(MODE_RESUME, 3'd2, 6'd1,  32'd0);
        send_word(MODE_SIGNAL, 3'd2, 6'd0,  32'd0);
        send_word(MODE_UNUSED, 3'd5, 6'd5,  32'd3);
        send_word(MODE_WAIT,   3'd7, 6'd16, 32'd0);
        wait_idle();
    endtask

    // A binary semaphore left holding more than one unit after the mask changes
    task automatic test_binary_over_one();
        write_reg(CFG_COUNTING_MASK, 64'hFF);
        write_reg(CFG_INITIAL_COUNTS, 64'h0000_0000_0500_0000);
        write_reg(CFG_COUNTING_MASK, 64'h00);
        send_word(MODE_WAIT,   3'd3, 6'd4, 32'd0);
        send_word(MODE_SIGNAL, 3'd3, 6'd4, 32'd0);
        send_word(MODE_WAIT,   3'd3, 6'd4, 32'd0);
        send_word(MODE_WAIT,   3'd3, 6'd4, 32'd0);
        wait_idle();
    endtask

    // Count a counting semaphore past the largest loadable value and back
    task automatic test_count_past_load();
        write_reg(CFG_COUNTING_MASK, 64'h01);
        write_reg(CFG_INITIAL_COUNTS, 64'hFF);
        send_word(MODE_SIGNAL, 3'd0, 6'd1, 32'd0);
        send_word(MODE_WAIT,   3'd0, 6'd1, 32'd0);
        send_word(MODE_SIGNAL, 3'd0, 6'd1, 32'd0);
        wait_idle();
    endtask

    // Hold the result side off while words keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(CFG_COUNTING_MASK, 64'h0F);
        write_reg(CFG_INITIAL_COUNTS, 64'h0102_0300_0102_0300);
        hold_requested++;
        for (int i = 0; i < 80; i++) begin
            send_random_op(3'($urandom_range(0, 7)), $urandom_range(1, 29));
        end
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [63:0] mask_val;
        logic [63:0] counts_val;
        logic [2:0]  sem_focus;
        int          prio_base;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin mask_val = 64'h00; counts_val = 64'h0; end
                1: begin mask_val = 64'hFF; counts_val = '1; end
                2: begin mask_val = 64'hFF; counts_val = 64'h0; end
                3: begin mask_val = 64'h00; counts_val = '1; end
                default: begin
                    mask_val   = 64'($urandom_range(0, 255));
                    counts_val = {32'($urandom), 32'($urandom)};
                end
            endcase
            write_reg(CFG_COUNTING_MASK, mask_val);
            // the last phase keeps its counts across the mask change
            if (p != 5) begin
                write_reg(CFG_INITIAL_COUNTS, counts_val);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) begin
                    sem_focus = 3'($urandom_range(0, 7));
                    prio_base = $urandom_range(1, 29);
                end
                send_random_op(sem_focus, prio_base);
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_priorities();
        test_binary_over_one();
        test_count_past_load();
        test_backpressure();
        test_random_phases();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
